@@ design/vrrm_pkg.sv @@
// ----------------------------------------------------------------------------
// vrrm_pkg
// Shared widths, defaults and payload types of the virtual register rename map.
// ----------------------------------------------------------------------------
package vrrm_pkg;

	localparam int CLASS_W         = 2;
	localparam int NUMBER_W        = 10;
	localparam int PHYS_W          = 10;
	localparam int ENTRY_W         = PHYS_W + 1;
	// fixed point reciprocal used to reduce a number modulo REG_NUMBERS
	localparam int RECIP_SHIFT     = 20;
	localparam int RECIP_W         = 20;
	// wide enough to hold the largest REG_NUMBERS
	localparam int NMAX_W          = 17;
	localparam int DEF_REG_NUMBERS = 1024;
	localparam int DEF_REG_CLASSES = 4;
	// items that can be in flight between input transfer and result transfer
	localparam int PIPE_DEPTH      = 5;

	typedef struct packed {
		logic [CLASS_W-1:0]  reg_class;
		logic [NUMBER_W-1:0] reg_number;
	} item_t;

	typedef struct packed {
		logic [PHYS_W-1:0] phys_register;
		logic              newly_mapped;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} lookup_t;

endpackage

@@ design/vrrm_num_reduce.sv @@
// ----------------------------------------------------------------------------
// vrrm_num_reduce
// Three stage front end: folds the class and the virtual number into range.
// ----------------------------------------------------------------------------
module vrrm_num_reduce #(
	parameter int REG_NUMBERS = vrrm_pkg::DEF_REG_NUMBERS,
	parameter int REG_CLASSES = vrrm_pkg::DEF_REG_CLASSES,
	localparam int CLS_W = (REG_CLASSES > 2) ? $clog2(REG_CLASSES) : 1,
	localparam int NUM_W = ($clog2(REG_NUMBERS) < vrrm_pkg::NUMBER_W) ?
		$clog2(REG_NUMBERS) : vrrm_pkg::NUMBER_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_take,
	input  vrrm_pkg::item_t      item,
	output logic                 req_valid,
	output logic [CLS_W-1:0]     req_cls,
	output logic [NUM_W-1:0]     req_num
);
	import vrrm_pkg::*;

	localparam int PROD_W = NUMBER_W + RECIP_W;
	localparam int QN_W   = NUMBER_W + NMAX_W;
	localparam logic [RECIP_W-1:0]   RECIP   = RECIP_W'((1 << RECIP_SHIFT) / REG_NUMBERS);
	localparam logic [NMAX_W-1:0]    NUMS    = NMAX_W'(REG_NUMBERS);
	localparam logic [CLASS_W+1:0]   CLASSES = (CLASS_W + 2)'(REG_CLASSES);

	logic [CLASS_W+1:0]  cls_red;
	logic [PROD_W-1:0]   x_ext;
	logic                valid_s1, valid_s2, valid_s3;
	logic [CLS_W-1:0]    cls_s1, cls_s2, cls_s3;
	logic [NUMBER_W-1:0] x_s1, x_s2;
	logic [PROD_W-1:0]   prod_s1;
	logic [NUMBER_W-1:0] q_s1;
	logic [QN_W-1:0]     qn_full;
	logic [NUMBER_W-1:0] qn_s2;
	logic [NUMBER_W-1:0] r_raw;
	logic [NMAX_W-1:0]   r_ext, r_fix;
	logic [NUM_W-1:0]    num_s3;

	// a two bit class needs at most three subtract steps
	always_comb begin
		cls_red = (CLASS_W + 2)'(item.reg_class);
		for (int i = 0; i < 3; i++) begin
			if (cls_red >= CLASSES) begin
				cls_red = cls_red - CLASSES;
			end
		end
	end

	assign x_ext   = PROD_W'(item.reg_number);
	// estimate of number / REG_NUMBERS, low by at most one
	assign q_s1    = prod_s1[RECIP_SHIFT +: NUMBER_W];
	assign qn_full = QN_W'(q_s1) * QN_W'(NUMS);
	assign r_raw   = x_s2 - qn_s2;
	assign r_ext   = NMAX_W'(r_raw);
	assign r_fix   = (r_ext >= NUMS) ? (r_ext - NUMS) : r_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= CLS_W'(cls_red);
			x_s1    <= item.reg_number;
			prod_s1 <= x_ext * PROD_W'(RECIP);
			cls_s2  <= cls_s1;
			x_s2    <= x_s1;
			qn_s2   <= qn_full[NUMBER_W-1:0];
			cls_s3  <= cls_s2;
			num_s3  <= r_fix[NUM_W-1:0];
		end
	end

	assign req_valid = valid_s3;
	assign req_cls   = cls_s3;
	assign req_num   = num_s3;

endmodule

@@ design/vrrm_map_table.sv @@
// ----------------------------------------------------------------------------
// vrrm_map_table
// Rename table memory with read, allocate and write back, plus class counters.
// ----------------------------------------------------------------------------
module vrrm_map_table #(
	parameter int REG_NUMBERS = vrrm_pkg::DEF_REG_NUMBERS,
	parameter int REG_CLASSES = vrrm_pkg::DEF_REG_CLASSES,
	localparam int CLS_W = (REG_CLASSES > 2) ? $clog2(REG_CLASSES) : 1,
	localparam int NUM_W = ($clog2(REG_NUMBERS) < vrrm_pkg::NUMBER_W) ?
		$clog2(REG_NUMBERS) : vrrm_pkg::NUMBER_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              identity_mode,
	input  logic              req_valid,
	input  logic [CLS_W-1:0]  req_cls,
	input  logic [NUM_W-1:0]  req_num,
	output logic              clearing,
	output vrrm_pkg::lookup_t look
);
	import vrrm_pkg::*;

	localparam int DEPTH  = REG_CLASSES << NUM_W;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [ADDR_W-1:0]  rd_addr, addr_s4, clr_addr_q, wr_addr;
	logic               clr_busy_q;
	logic [ENTRY_W-1:0] rdata_s4, entry_s4, wr_data;
	logic               wr_en;
	logic               valid_s4;
	logic [CLS_W-1:0]   cls_s4;
	logic [NUM_W-1:0]   num_s4;
	logic               fwd_s4;
	logic [PHYS_W-1:0]  fwd_phys_s4;
	logic [PHYS_W-1:0]  next_free_q [REG_CLASSES];
	logic               hit, alloc;
	logic [PHYS_W-1:0]  phys;

	assign rd_addr = ADDR_W'({req_cls, req_num});

	// reads and the write back share the advancing edge, so a read of the entry
	// being written picks up the new mapping through the bypass
	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s4 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			fwd_s4   <= 1'b0;
		end else if (adv) begin
			valid_s4 <= req_valid;
			fwd_s4   <= alloc && (addr_s4 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s4     <= rd_addr;
			cls_s4      <= req_cls;
			num_s4      <= req_num;
			fwd_phys_s4 <= phys;
		end
	end

	// clearing pass after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	assign entry_s4 = fwd_s4 ? {1'b1, fwd_phys_s4} : rdata_s4;
	assign hit      = entry_s4[ENTRY_W-1];
	assign alloc    = valid_s4 && !hit;

	always_comb begin
		priority if (hit) begin
			phys = entry_s4[PHYS_W-1:0];
		end else if (identity_mode) begin
			phys = PHYS_W'(num_s4);
		end else begin
			phys = next_free_q[cls_s4];
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = adv && alloc;
			wr_addr = addr_s4;
			wr_data = {1'b1, phys};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_CLASSES; i++) begin
				next_free_q[i] <= '0;
			end
		end else if (adv && alloc && !identity_mode) begin
			next_free_q[cls_s4] <= next_free_q[cls_s4] + PHYS_W'(1);
		end
	end

	assign clearing               = clr_busy_q;
	assign look.valid             = valid_s4;
	assign look.res.phys_register = phys;
	assign look.res.newly_mapped  = !hit;

endmodule

@@ design/virtual_register_rename_map.sv @@
// ----------------------------------------------------------------------------
// virtual_register_rename_map
// Maps (class, virtual number) pairs to physical registers, allocating on miss.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  item    | in        | item_valid / item_ready      | vrrm_pkg::item_t
//  result  | out       | result_valid / result_ready  | vrrm_pkg::result_t
//  config  | in        | cfg_we (no wait)             | cfg_data (identity mode)
//
// one item per cycle sustained while results are taken; result_valid rises once the item
// has moved through the input stage, two reduction stages and the table read into the result register.
// after reset the table is swept clear, all REG_CLASSES * 2**min(clog2(REG_NUMBERS),10)
// entries (4096 by default), with item_ready low.
// a result waiting on result_ready holds the whole pipeline, table port included.
// ----------------------------------------------------------------------------
module virtual_register_rename_map #(
	parameter int REG_NUMBERS = vrrm_pkg::DEF_REG_NUMBERS,
	parameter int REG_CLASSES = vrrm_pkg::DEF_REG_CLASSES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  vrrm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output vrrm_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_data
);
	import vrrm_pkg::*;

	localparam int CLS_W = (REG_CLASSES > 2) ? $clog2(REG_CLASSES) : 1;
	localparam int NUM_W = ($clog2(REG_NUMBERS) < NUMBER_W) ? $clog2(REG_NUMBERS) : NUMBER_W;

	logic             adv, in_take, clearing;
	logic             identity_q;
	logic             req_valid;
	logic [CLS_W-1:0] req_cls;
	logic [NUM_W-1:0] req_num;
	lookup_t          look;
	logic             res_valid_q;
	result_t          result_q;

	assign adv        = !res_valid_q || result_ready;
	assign item_ready = adv && !clearing;
	assign in_take    = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			identity_q <= 1'b0;
		end else if (cfg_we) begin
			identity_q <= cfg_data;
		end
	end

	vrrm_num_reduce #(
		.REG_NUMBERS (REG_NUMBERS),
		.REG_CLASSES (REG_CLASSES)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_take   (in_take),
		.item      (item),
		.req_valid (req_valid),
		.req_cls   (req_cls),
		.req_num   (req_num)
	);

	vrrm_map_table #(
		.REG_NUMBERS (REG_NUMBERS),
		.REG_CLASSES (REG_CLASSES)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.identity_mode (identity_q),
		.req_valid     (req_valid),
		.req_cls       (req_cls),
		.req_num       (req_num),
		.clearing      (clearing),
		.look          (look)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= look.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && look.valid) begin
			result_q <= look.res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule

@@ design/vrrm_checker.sv @@
// ----------------------------------------------------------------------------
// vrrm_checker
// Port level checks of the rename map, bound to the top level.
// ----------------------------------------------------------------------------
module vrrm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input vrrm_pkg::result_t result
);
	import vrrm_pkg::*;

	logic [3:0] outstanding_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = item_valid && item_ready;
	assign out_xfer = result_valid && result_ready;

	// items taken in whose result has not been transferred yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 4'(in_xfer) - 4'(out_xfer);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outstanding_q != 4'd0)
		else $error("result without a pending item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 4'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("item taken while the result register is stalled");

endmodule

bind virtual_register_rename_map vrrm_checker u_vrrm_checker (.*);
